// File: src/monochrome_page_framebuffer_engine_unit_macros.svh
// Assertion macros shared by the framebuffer engine modules.
// Needs nothing else; included by the files that carry assertions.
`ifndef MONOCHROME_PAGE_FRAMEBUFFER_ENGINE_UNIT_MACROS_SVH
`define MONOCHROME_PAGE_FRAMEBUFFER_ENGINE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPFE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MPFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/mpfe_pkg.sv
// Shared types, codes and the 5x7 font table of the framebuffer engine.
// Depends on nothing; imported by the controller, datapath and top level.
package mpfe_pkg;

   localparam int COL_BITS   = 8;
   localparam int PAGE_BITS  = 5;
   localparam int GLYPH_COLS = 6;

   localparam logic [7:0] FIRST_CODE    = 8'h20;
   localparam logic [7:0] LAST_CODE     = 8'h7E;
   localparam logic [7:0] FALLBACK_CODE = 8'h3F;

   localparam logic [2:0] MODE_CLEAR = 3'd0;
   localparam logic [2:0] MODE_PIXEL = 3'd1;
   localparam logic [2:0] MODE_LINE  = 3'd2;
   localparam logic [2:0] MODE_GLYPH = 3'd3;
   localparam logic [2:0] MODE_READ  = 3'd4;

   // Five font columns, column 0 first.
   typedef logic [0:4][7:0] glyph_type;

   typedef enum logic [2:0] {
      KIND_CLEAR,
      KIND_RMW,
      KIND_GLYPH,
      KIND_READ,
      KIND_REJECT
   } kind_type;

   typedef enum logic [1:0] {
      WSEL_ZERO,
      WSEL_MOD,
      WSEL_GLYPH
   } wsel_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_CLEAR,
      S_FETCH,
      S_MODIFY,
      S_GLYPH,
      S_DONE
   } state_type;

   typedef struct packed {
      logic     load;
      logic     we;
      wsel_type wsel;
      logic     addr_clr;
      logic     clr_step;
      logic     col_step;
      logic     post;
   } cmd_type;

   typedef struct packed {
      kind_type new_kind;
      kind_type kind;
      logic     col_last;
      logic     clr_last;
      logic     glyph_last;
      logic     rsp_free;
   } status_type;

   function automatic glyph_type font_glyph(input logic [7:0] code);
      logic [6:0] idx;
      glyph_type  g;
      if (code < FIRST_CODE || code > LAST_CODE) begin
         idx = 7'(FALLBACK_CODE - FIRST_CODE);
      end else begin
         idx = 7'(code - FIRST_CODE);
      end
      unique case (idx)
         7'd0:  g = 40'h0000000000;
         7'd1:  g = 40'h00005F0000;
         7'd2:  g = 40'h0007000700;
         7'd3:  g = 40'h147F147F14;
         7'd4:  g = 40'h242A7F2A12;
         7'd5:  g = 40'h2313086462;
         7'd6:  g = 40'h3649552250;
         7'd7:  g = 40'h0005030000;
         7'd8:  g = 40'h001C224100;
         7'd9:  g = 40'h0041221C00;
         7'd10: g = 40'h14083E0814;
         7'd11: g = 40'h08083E0808;
         7'd12: g = 40'h0050300000;
         7'd13: g = 40'h0808080808;
         7'd14: g = 40'h0060600000;
         7'd15: g = 40'h2010080402;
         7'd16: g = 40'h3E5149453E;
         7'd17: g = 40'h00427F4000;
         7'd18: g = 40'h4261514946;
         7'd19: g = 40'h2141454B31;
         7'd20: g = 40'h1814127F10;
         7'd21: g = 40'h2745454539;
         7'd22: g = 40'h3C4A494930;
         7'd23: g = 40'h0171090503;
         7'd24: g = 40'h3649494936;
         7'd25: g = 40'h064949291E;
         7'd26: g = 40'h0036360000;
         7'd27: g = 40'h0056360000;
         7'd28: g = 40'h0814224100;
         7'd29: g = 40'h1414141414;
         7'd30: g = 40'h0041221408;
         7'd31: g = 40'h0201510906;
         7'd32: g = 40'h324979413E;
         7'd33: g = 40'h7E1111117E;
         7'd34: g = 40'h7F49494936;
         7'd35: g = 40'h3E41414122;
         7'd36: g = 40'h7F4141221C;
         7'd37: g = 40'h7F49494941;
         7'd38: g = 40'h7F09090901;
         7'd39: g = 40'h3E4149497A;
         7'd40: g = 40'h7F0808087F;
         7'd41: g = 40'h00417F4100;
         7'd42: g = 40'h2040413F01;
         7'd43: g = 40'h7F08142241;
         7'd44: g = 40'h7F40404040;
         7'd45: g = 40'h7F020C027F;
         7'd46: g = 40'h7F0408107F;
         7'd47: g = 40'h3E4141413E;
         7'd48: g = 40'h7F09090906;
         7'd49: g = 40'h3E4151215E;
         7'd50: g = 40'h7F09192946;
         7'd51: g = 40'h4649494931;
         7'd52: g = 40'h01017F0101;
         7'd53: g = 40'h3F4040403F;
         7'd54: g = 40'h1F2040201F;
         7'd55: g = 40'h7F2018207F;
         7'd56: g = 40'h6314081463;
         7'd57: g = 40'h0708700807;
         7'd58: g = 40'h6151494543;
         7'd59: g = 40'h007F414100;
         7'd60: g = 40'h0204081020;
         7'd61: g = 40'h0041417F00;
         7'd62: g = 40'h0402010204;
         7'd63: g = 40'h4040404040;
         7'd64: g = 40'h0001020000;
         7'd65: g = 40'h2054545478;
         7'd66: g = 40'h7F48444438;
         7'd67: g = 40'h3844444420;
         7'd68: g = 40'h384444487F;
         7'd69: g = 40'h3854545418;
         7'd70: g = 40'h087E090102;
         7'd71: g = 40'h0C5252523E;
         7'd72: g = 40'h7F08040478;
         7'd73: g = 40'h00447D4000;
         7'd74: g = 40'h2040443D00;
         7'd75: g = 40'h7F10284400;
         7'd76: g = 40'h00417F4000;
         7'd77: g = 40'h7C04180478;
         7'd78: g = 40'h7C08040478;
         7'd79: g = 40'h3844444438;
         7'd80: g = 40'h7C14141408;
         7'd81: g = 40'h081414147C;
         7'd82: g = 40'h7C08040408;
         7'd83: g = 40'h4854545420;
         7'd84: g = 40'h043F444020;
         7'd85: g = 40'h3C4040207C;
         7'd86: g = 40'h1C2040201C;
         7'd87: g = 40'h3C4030403C;
         7'd88: g = 40'h4428102844;
         7'd89: g = 40'h0C5050503C;
         7'd90: g = 40'h4464544C44;
         7'd91: g = 40'h0008364100;
         7'd92: g = 40'h00007F0000;
         7'd93: g = 40'h0041360800;
         7'd94: g = 40'h0804081008;
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

// File: src/mpfe_ctrl.sv
// Command sequencer of the framebuffer engine: one state machine.
// Depends on mpfe_pkg and the shared assertion macros.
`include "monochrome_page_framebuffer_engine_unit_macros.svh"

module mpfe_ctrl
   import mpfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               unique case (status.new_kind)
                  KIND_CLEAR:  state_in = S_CLEAR;
                  KIND_RMW:    state_in = S_FETCH;
                  KIND_GLYPH:  state_in = S_GLYPH;
                  KIND_READ:   state_in = S_FETCH;
                  KIND_REJECT: state_in = S_DONE;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_CLEAR: begin
            if (status.clr_last) state_in = S_DONE;
         end
         S_FETCH: begin
            state_in = (status.kind == KIND_READ) ? S_DONE : S_MODIFY;
         end
         S_MODIFY: begin
            state_in = status.col_last ? S_DONE : S_FETCH;
         end
         S_GLYPH: begin
            if (status.glyph_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (status.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.wsel  = WSEL_ZERO;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_INIT, S_CLEAR: begin
            cmd.we       = 1'b1;
            cmd.wsel     = WSEL_ZERO;
            cmd.addr_clr = 1'b1;
            cmd.clr_step = 1'b1;
         end
         S_IDLE: begin
            cmd.load = req_valid;
         end
         S_FETCH: begin
            cmd.we = 1'b0;
         end
         S_MODIFY: begin
            cmd.we       = 1'b1;
            cmd.wsel     = WSEL_MOD;
            cmd.col_step = 1'b1;
         end
         S_GLYPH: begin
            cmd.we       = 1'b1;
            cmd.wsel     = WSEL_GLYPH;
            cmd.col_step = 1'b1;
         end
         S_DONE: begin
            cmd.post = status.rsp_free;
         end
         default: cmd.load = 1'b0;
      endcase
   end

   `MPFE_ASSERT_NEXT(a_accept_leaves_idle, clock, reset,
      state_ff == S_IDLE && req_valid, state_ff != S_IDLE, "accepted item did not start")
   `MPFE_ASSERT_SAME(a_post_needs_room, clock, reset,
      cmd.post, status.rsp_free, "result posted over an unread result")
   `MPFE_ASSERT_SAME(a_no_write_while_idle, clock, reset,
      cmd.we, state_ff != S_IDLE && state_ff != S_DONE, "store written outside a command")

endmodule

// File: src/mpfe_dpath.sv
// Datapath of the framebuffer engine: command decode, page store,
// column and sweep counters, and the result register. Depends on mpfe_pkg.
`include "monochrome_page_framebuffer_engine_unit_macros.svh"

module mpfe_dpath
   import mpfe_pkg::*;
#(
   parameter int DISPLAY_WIDTH = 128,
   parameter int DISPLAY_PAGES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [2:0]          req_mode,
   input  logic [COL_BITS-1:0] req_x,
   input  logic [COL_BITS-1:0] req_x_end,
   input  logic [7:0]          req_y,
   input  logic                req_pixel_on,
   input  logic [7:0]          req_page,
   input  logic [7:0]          req_char_code,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_read_data,
   output logic                rsp_rejected
);

   localparam int DEPTH  = DISPLAY_WIDTH * DISPLAY_PAGES;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic [8:0] WIDTH9   = 9'(DISPLAY_WIDTH);
   localparam logic [8:0] ROWS9    = 9'(DISPLAY_PAGES * 8);
   localparam logic [8:0] PAGES9   = 9'(DISPLAY_PAGES);
   localparam logic [8:0] GLYPHX9  = 9'(DISPLAY_WIDTH - GLYPH_COLS);

   logic [7:0] mem [DEPTH];

   kind_type            kind_ff;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [COL_BITS-1:0] hi_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic [2:0]          bit_ff;
   logic                set_ff;
   glyph_type           glyph_ff;
   logic [2:0]          cnt_ff, cnt_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [7:0]          rd_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_read_data_ff;
   logic                rsp_rejected_ff;

   kind_type             new_kind;
   logic [COL_BITS-1:0]  new_col, new_hi, line_lo, line_hi;
   logic [PAGE_BITS-1:0] new_page;
   logic [ADDR_W-1:0]    col_addr, mem_addr;
   logic [7:0]           mask, wdata;

   // Decode of the offered command; range checks happen here, once.
   always_comb begin
      line_lo  = (req_x_end < req_x) ? req_x_end : req_x;
      line_hi  = (req_x_end < req_x) ? req_x : req_x_end;
      new_col  = req_x;
      new_hi   = req_x;
      new_page = req_page[PAGE_BITS-1:0];
      new_kind = KIND_REJECT;
      unique case (req_mode)
         MODE_CLEAR: new_kind = KIND_CLEAR;
         MODE_PIXEL: begin
            new_page = req_y[7:3];
            if ({1'b0, req_x} < WIDTH9 && {1'b0, req_y} < ROWS9) new_kind = KIND_RMW;
         end
         MODE_LINE: begin
            new_page = req_y[7:3];
            new_col  = line_lo;
            new_hi   = ({1'b0, line_hi} >= WIDTH9) ? COL_BITS'(DISPLAY_WIDTH - 1) : line_hi;
            if ({1'b0, req_y} < ROWS9 && {1'b0, line_lo} < WIDTH9) new_kind = KIND_RMW;
         end
         MODE_GLYPH: begin
            if ({1'b0, req_page} < PAGES9 && {1'b0, req_x} <= GLYPHX9) new_kind = KIND_GLYPH;
         end
         MODE_READ: begin
            if ({1'b0, req_x} < WIDTH9 && {1'b0, req_page} < PAGES9) new_kind = KIND_READ;
         end
         default: new_kind = KIND_REJECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= new_kind;
         hi_ff    <= new_hi;
         page_ff  <= new_page;
         bit_ff   <= req_y[2:0];
         set_ff   <= (req_mode == MODE_LINE) | req_pixel_on;
         glyph_ff <= font_glyph(req_char_code);
      end
   end

   always_comb begin
      col_in = col_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         col_in = new_col;
         cnt_in = '0;
      end else if (cmd.col_step) begin
         col_in = col_ff + 1'b1;
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      clr_in = clr_ff;
      if (cmd.load) begin
         clr_in = '0;
      end else if (cmd.clr_step) begin
         clr_in = clr_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.post) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Store address is page * width + column.
   always_comb begin
      col_addr = ADDR_W'(page_ff) * ADDR_W'(DISPLAY_WIDTH) + ADDR_W'(col_ff);
      mem_addr = cmd.addr_clr ? clr_ff : col_addr;
      mask     = 8'h01 << bit_ff;
      unique case (cmd.wsel)
         WSEL_ZERO:  wdata = 8'h00;
         WSEL_MOD:   wdata = set_ff ? (rd_data_ff | mask) : (rd_data_ff & ~mask);
         WSEL_GLYPH: wdata = (cnt_ff == 3'(GLYPH_COLS - 1)) ? 8'h00 : glyph_ff[cnt_ff];
         default:    wdata = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[mem_addr] <= wdata;
      end
      rd_data_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.post) begin
         rsp_read_data_ff <= (kind_ff == KIND_READ) ? rd_data_ff : 8'h00;
         rsp_rejected_ff  <= (kind_ff == KIND_REJECT);
      end
   end

   always_comb begin
      status.new_kind   = new_kind;
      status.kind       = kind_ff;
      status.col_last   = (col_ff == hi_ff);
      status.clr_last   = (clr_ff == ADDR_W'(DEPTH - 1));
      status.glyph_last = (cnt_ff == 3'(GLYPH_COLS - 1));
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_rejected  = rsp_rejected_ff;

   `MPFE_ASSERT_SAME(a_reject_has_no_data, clock, reset,
      rsp_valid_ff && rsp_rejected_ff, rsp_read_data_ff == 8'h00, "rejected item carries data")
   `MPFE_ASSERT_SAME(a_sweep_in_range, clock, reset,
      cmd.addr_clr, {1'b0, clr_ff} < (ADDR_W + 1)'(DEPTH), "clear sweep beyond the store")
   `MPFE_ASSERT_SAME(a_column_in_range, clock, reset,
      cmd.we && !cmd.addr_clr, {1'b0, col_ff} < WIDTH9, "column write beyond the width")

endmodule

// File: src/monochrome_page_framebuffer_engine_unit.sv
// Per item: a pixel is fetched and then modified; a line fetches and modifies each column
// in turn; a glyph writes its six columns; a read fetches one byte; a rejected command
// goes straight to its result; a clear sweeps all W*P bytes (W*P = 1024 at the defaults).
// One item is in work at a time; every pixel, column and glyph byte passes through the
// single-port page store. Reset is synchronous: after reset the store is swept to zero
// one byte a cycle, and req_stall stays high until that sweep is done.
//
// Top level of the page-organized monochrome framebuffer engine.
// Depends on mpfe_pkg, mpfe_ctrl and mpfe_dpath.
module monochrome_page_framebuffer_engine_unit
   import mpfe_pkg::*;
#(
   parameter int DISPLAY_WIDTH = 128,
   parameter int DISPLAY_PAGES = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_x,
   input  logic [7:0] req_x_end,
   input  logic [7:0] req_y,
   input  logic       req_pixel_on,
   input  logic [7:0] req_page,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_rejected
);

   // The controller only sequences; every address, byte and range check
   // lives in the datapath, which reports back through the status struct.
   cmd_type    cmd;
   status_type status;

   mpfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the page store and the result register. A finished
   // result waits there while the controller already returns to idle, so
   // the next item is taken even while the consumer is stalling.
   mpfe_dpath #(
      .DISPLAY_WIDTH (DISPLAY_WIDTH),
      .DISPLAY_PAGES (DISPLAY_PAGES)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_mode      (req_mode),
      .req_x         (req_x),
      .req_x_end     (req_x_end),
      .req_y         (req_y),
      .req_pixel_on  (req_pixel_on),
      .req_page      (req_page),
      .req_char_code (req_char_code),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_data (rsp_read_data),
      .rsp_rejected  (rsp_rejected)
   );

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the page-organized monochrome framebuffer engine.
// Depends on mpfe_pkg for the mode codes and character bounds, and on the
// monochrome_page_framebuffer_engine_unit RTL; it predicts every result in SystemVerilog.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mpfe_pkg::*;

   localparam int FB_WIDTH    = 128;
   localparam int FB_PAGES    = 8;
   localparam int FB_HEIGHT   = FB_PAGES * 8;
   localparam int HOLD_CYCLES = 600;

   // One drawing command item, as it is offered on the request channel.
   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] x;
      logic [7:0] x_end;
      logic [7:0] y;
      logic       pixel_on;
      logic [7:0] page;
      logic [7:0] char_code;
   } draw_cmd_type;

   // One result item, as it is returned on the response channel.
   typedef struct packed {
      logic [7:0] read_data;
      logic       rejected;
   } readout_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic [2:0] req_mode      = '0;
   logic [7:0] req_x         = '0;
   logic [7:0] req_x_end     = '0;
   logic [7:0] req_y         = '0;
   logic       req_pixel_on  = 1'b0;
   logic [7:0] req_page      = '0;
   logic [7:0] req_char_code = '0;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_rejected;

   // Our own copy of the page store, addressed as page * width + column.
   logic [7:0] frame_bytes [0:FB_WIDTH*FB_PAGES-1];

   // 5x7 font, one entry per printable code starting at space; column 0 is the top byte.
   logic [39:0] font_cols [0:94] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
      40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
      40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
      40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
      40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
      40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h7F2018207F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020000,
      40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
      40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414147C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
      40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0804081008
   };

   // Results still owed by the engine, oldest first.
   readout_type pending_readouts [$];

   int mismatches       = 0;
   int send_idle_pct    = 0;
   int recv_stall_pct   = 0;
   int hold_requests    = 0;
   int hold_served      = 0;
   int hold_cycles_left = 0;
   int mode_counts [0:7] = '{default: 0};
   int rejected_seen    = 0;
   int nonzero_reads    = 0;

   monochrome_page_framebuffer_engine_unit #(
      .DISPLAY_WIDTH(FB_WIDTH),
      .DISPLAY_PAGES(FB_PAGES)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_x        (req_x),
      .req_x_end    (req_x_end),
      .req_y        (req_y),
      .req_pixel_on (req_pixel_on),
      .req_page     (req_page),
      .req_char_code(req_char_code),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_read_data(rsp_read_data),
      .rsp_rejected (rsp_rejected)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one accepted command to our copy of the store and return the result
   // that the engine owes for it.
   function automatic readout_type apply_draw_command(input draw_cmd_type c);
      readout_type r;
      int          lo;
      int          hi;
      int          base;
      logic [7:0]  code;
      logic [39:0] glyph;
      r = '0;
      mode_counts[c.mode]++;
      unique case (c.mode)
         MODE_CLEAR: begin
            foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
         end
         MODE_PIXEL: begin
            if (c.x >= FB_WIDTH || c.y >= FB_HEIGHT) begin
               r.rejected = 1'b1;
            end else begin
               base = (c.y / 8) * FB_WIDTH + c.x;
               if (c.pixel_on) frame_bytes[base] |= 8'(1 << c.y[2:0]);
               else frame_bytes[base] &= ~8'(1 << c.y[2:0]);
            end
         end
         MODE_LINE: begin
            lo = c.x;
            hi = c.x_end;
            if (hi < lo) begin
               lo = c.x_end;
               hi = c.x;
            end
            if (c.y >= FB_HEIGHT || lo >= FB_WIDTH) begin
               r.rejected = 1'b1;
            end else begin
               // The far end is clipped to the last column; that is not a rejection.
               if (hi >= FB_WIDTH) hi = FB_WIDTH - 1;
               base = (c.y / 8) * FB_WIDTH;
               for (int col = lo; col <= hi; col++) begin
                  frame_bytes[base + col] |= 8'(1 << c.y[2:0]);
               end
            end
         end
         MODE_GLYPH: begin
            if (c.page >= FB_PAGES || c.x > FB_WIDTH - GLYPH_COLS) begin
               r.rejected = 1'b1;
            end else begin
               code = c.char_code;
               if (code < FIRST_CODE || code > LAST_CODE) code = FALLBACK_CODE;
               glyph = font_cols[code - FIRST_CODE];
               base = c.page * FB_WIDTH + c.x;
               for (int i = 0; i < 5; i++) frame_bytes[base + i] = glyph[39 - 8*i -: 8];
               // The spacing column is always blanked.
               frame_bytes[base + 5] = 8'h00;
            end
         end
         MODE_READ: begin
            if (c.x >= FB_WIDTH || c.page >= FB_PAGES) r.rejected = 1'b1;
            else r.read_data = frame_bytes[c.page * FB_WIDTH + c.x];
         end
         default: begin
            r.rejected = 1'b1;
         end
      endcase
      return r;
   endfunction

   function automatic draw_cmd_type make_cmd(input logic [2:0] mode, input int x,
                                             input int x_end, input int y, input logic on,
                                             input int page, input int code);
      draw_cmd_type c;
      c.mode      = mode;
      c.x         = 8'(x);
      c.x_end     = 8'(x_end);
      c.y         = 8'(y);
      c.pixel_on  = on;
      c.page      = 8'(page);
      c.char_code = 8'(code);
      return c;
   endfunction

   // Random command: mostly well-formed drawing with short lines, plenty of reads to
   // observe the store, rare clears, and some out-of-range or undefined commands.
   function automatic draw_cmd_type random_draw_command();
      draw_cmd_type c;
      int           pick;
      int           lo;
      int           hi;
      logic         in_range;
      c.mode      = MODE_READ;
      c.x         = 8'($urandom);
      c.x_end     = 8'($urandom);
      c.y         = 8'($urandom);
      c.pixel_on  = 1'($urandom);
      c.page      = 8'($urandom);
      c.char_code = 8'($urandom);
      pick        = $urandom_range(0, 99);
      in_range    = ($urandom_range(0, 99) < 88);
      if (pick < 1) begin
         c.mode = MODE_CLEAR;
      end else if (pick < 28) begin
         c.mode = MODE_PIXEL;
         if (in_range) begin
            c.x = 8'($urandom_range(0, FB_WIDTH - 1));
            c.y = 8'($urandom_range(0, FB_HEIGHT - 1));
         end
      end else if (pick < 45) begin
         c.mode = MODE_LINE;
         if (in_range) begin
            c.y = 8'($urandom_range(0, FB_HEIGHT - 1));
            lo  = $urandom_range(0, FB_WIDTH - 1);
            hi  = lo + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 12));
            if (hi > 255) hi = 255;
            if ($urandom_range(0, 1) == 1) begin
               c.x     = 8'(lo);
               c.x_end = 8'(hi);
            end else begin
               c.x     = 8'(hi);
               c.x_end = 8'(lo);
            end
         end
      end else if (pick < 67) begin
         c.mode = MODE_GLYPH;
         if (in_range) begin
            c.page = 8'($urandom_range(0, FB_PAGES - 1));
            c.x    = 8'($urandom_range(0, FB_WIDTH - GLYPH_COLS));
         end
         if ($urandom_range(0, 4) != 0) c.char_code = 8'($urandom_range(FIRST_CODE, LAST_CODE));
      end else if (pick < 97) begin
         c.mode = MODE_READ;
         if (in_range) begin
            c.x    = 8'($urandom_range(0, FB_WIDTH - 1));
            c.page = 8'($urandom_range(0, FB_PAGES - 1));
         end
      end else begin
         c.mode = 3'(MODE_READ + $urandom_range(1, 3));
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
      mismatches++;
   endtask

   // Offer one item, possibly after an idle gap, and predict its result once the
   // engine takes it. Called at a rising edge and returns at the accepting edge.
   task automatic send_cmd(input draw_cmd_type c);
      int gap;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 12) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= c.mode;
      req_x         <= c.x;
      req_x_end     <= c.x_end;
      req_y         <= c.y;
      req_pixel_on  <= c.pixel_on;
      req_page      <= c.page;
      req_char_code <= c.char_code;
      do @(posedge clock); while (req_stall);
      pending_readouts.push_back(apply_draw_command(c));
   endtask

   // Long receiver hold-off, counted here so the stall driver only has to look at it.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served      <= hold_requests;
         hold_cycles_left <= HOLD_CYCLES;
      end else if (hold_cycles_left > 0) begin
         hold_cycles_left <= hold_cycles_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (hold_cycles_left > 0) || ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Every result taken from the engine is compared with the oldest prediction.
   always @(posedge clock) begin : check_readouts
      readout_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_readouts.size() == 0) begin
            report_mismatch("result with no command pending", rsp_read_data, 0);
         end else begin
            want = pending_readouts.pop_front();
            if (rsp_read_data !== want.read_data) begin
               report_mismatch("read_data", rsp_read_data, want.read_data);
            end
            if (rsp_rejected !== want.rejected) begin
               report_mismatch("rejected", rsp_rejected, want.rejected);
            end
            if (rsp_rejected === 1'b1) rejected_seen++;
            if (!want.rejected && want.read_data != 8'h00) nonzero_reads++;
         end
      end
   end

   // Boundaries of every command and each dropped or adjusted case.
   task automatic test_directed_cases();
      send_cmd(make_cmd(MODE_CLEAR, 0, 0, 0, 1'b0, 0, 0));
      // Pixels at both corners (the far one set, the near one set then cleared), and just past each edge.
      send_cmd(make_cmd(MODE_PIXEL, FB_WIDTH - 1, 0, FB_HEIGHT - 1, 1'b1, 0, 0));
      send_cmd(make_cmd(MODE_READ, FB_WIDTH - 1, 0, 0, 1'b0, FB_PAGES - 1, 0));
      send_cmd(make_cmd(MODE_PIXEL, 0, 0, 0, 1'b1, 0, 0));
      send_cmd(make_cmd(MODE_PIXEL, 0, 0, 0, 1'b0, 0, 0));
      send_cmd(make_cmd(MODE_READ, 0, 0, 0, 1'b0, 0, 0));
      send_cmd(make_cmd(MODE_PIXEL, FB_WIDTH, 0, 0, 1'b1, 0, 0));
      send_cmd(make_cmd(MODE_PIXEL, 0, 0, FB_HEIGHT, 1'b1, 0, 0));
      // Lines: reversed endpoints, clipped far end, start past the edge, row past the bottom.
      send_cmd(make_cmd(MODE_LINE, 20, 10, 9, 1'b0, 0, 0));
      send_cmd(make_cmd(MODE_LINE, 120, 255, FB_HEIGHT - 1, 1'b0, 0, 0));
      send_cmd(make_cmd(MODE_LINE, 200, 130, 5, 1'b0, 0, 0));
      send_cmd(make_cmd(MODE_LINE, 0, 5, FB_HEIGHT, 1'b0, 0, 0));
      // Glyphs: rightmost legal column, one past it, bad page, unprintable codes, code bounds.
      send_cmd(make_cmd(MODE_GLYPH, FB_WIDTH - GLYPH_COLS, 0, 0, 1'b0, FB_PAGES - 1, 8'h41));
      send_cmd(make_cmd(MODE_READ, FB_WIDTH - GLYPH_COLS, 0, 0, 1'b0, FB_PAGES - 1, 0));
      send_cmd(make_cmd(MODE_GLYPH, FB_WIDTH - GLYPH_COLS + 1, 0, 0, 1'b0, 0, 8'h41));
      send_cmd(make_cmd(MODE_GLYPH, 0, 0, 0, 1'b0, FB_PAGES, 8'h41));
      send_cmd(make_cmd(MODE_GLYPH, 0, 0, 0, 1'b0, 0, FIRST_CODE - 1));
      send_cmd(make_cmd(MODE_GLYPH, 6, 0, 0, 1'b0, 0, LAST_CODE + 1));
      send_cmd(make_cmd(MODE_GLYPH, 12, 0, 0, 1'b0, 0, FIRST_CODE));
      send_cmd(make_cmd(MODE_GLYPH, 18, 0, 0, 1'b0, 0, LAST_CODE));
      // Reads past the last column and the last page.
      send_cmd(make_cmd(MODE_READ, 255, 0, 0, 1'b0, 0, 0));
      send_cmd(make_cmd(MODE_READ, 0, 0, 0, 1'b0, 255, 0));
      // The three undefined modes.
      for (int k = 1; k <= 3; k++) begin
         send_cmd(make_cmd(3'(MODE_READ + k), 0, 0, 0, 1'b1, 0, 0));
      end
   endtask

   task automatic test_random_traffic(input int send_pct, input int stall_pct, input int count);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_cmd(random_draw_command());
   endtask

   // The receiver holds off for a long stretch while items keep coming, so the
   // engine has to stall its request side until the response drains.
   task automatic test_backpressure();
      draw_cmd_type c;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests++;
      repeat (24) begin
         c = random_draw_command();
         if (c.mode == MODE_CLEAR) c.mode = MODE_READ;
         send_cmd(c);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic(0, 0, 500);
      test_backpressure();
      test_random_traffic(60, 0, 500);
      test_random_traffic(0, 60, 500);
      test_random_traffic(6, 6, 500);
      req_valid <= 1'b0;
      while (pending_readouts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered clear %0d, pixel %0d, line %0d, glyph %0d, read %0d, undefined %0d.",
               mode_counts[MODE_CLEAR], mode_counts[MODE_PIXEL], mode_counts[MODE_LINE],
               mode_counts[MODE_GLYPH], mode_counts[MODE_READ],
               mode_counts[5] + mode_counts[6] + mode_counts[7]);
      $display("Saw %0d dropped commands and %0d reads of nonzero bytes; %0d mismatches.",
               rejected_seen, nonzero_reads, mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Generous ceiling on the whole run; a hung handshake ends here.
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
